@@ hw/rtl/multilevel_feedback_queue_scheduler_macros.svh @@
// ----------------------------------------------------------------------------
// multilevel feedback queue scheduler assertion macros
// shared property shorthands for the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MFQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mfq_pkg.sv @@
// ----------------------------------------------------------------------------
// mfq_pkg
// types, codes and defaults of the multilevel feedback queue scheduler
// ----------------------------------------------------------------------------
package mfq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int TASK_ID_BITS_DEF = 8;
    localparam int LEVEL_BITS       = 2;
    localparam int QUANTUM_BITS     = 8;
    localparam int NUM_LEVELS       = 3;
    localparam int NUM_QUEUES       = 4;

    // queue slots
    localparam int Q_L1 = 0;
    localparam int Q_L2 = 1;
    localparam int Q_L3 = 2;
    localparam int Q_IO = 3;

    localparam logic [LEVEL_BITS-1:0] LVL_NONE = 2'd0;
    localparam logic [LEVEL_BITS-1:0] LVL_1    = 2'd1;
    localparam logic [LEVEL_BITS-1:0] LVL_2    = 2'd2;
    localparam logic [LEVEL_BITS-1:0] LVL_3    = 2'd3;

    localparam logic [QUANTUM_BITS-1:0] QUANTUM_L1_RST = 8'd1;
    localparam logic [QUANTUM_BITS-1:0] QUANTUM_L2_RST = 8'd2;
    localparam logic [QUANTUM_BITS-1:0] QUANTUM_L3_RST = 8'd4;

    typedef enum logic [1:0] {
        MODE_ADMIT    = 2'd0,
        MODE_DISPATCH = 2'd1,
        MODE_REPORT   = 2'd2,
        MODE_IO_DONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OUT_EXPIRED    = 2'd0,
        OUT_IO_REQUEST = 2'd1,
        OUT_TERMINATED = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        RES_OK          = 3'd0,
        RES_EMPTY       = 3'd1,
        RES_FULL        = 3'd2,
        RES_NOT_RUNNING = 3'd3,
        RES_BUSY        = 3'd4
    } t_result;

    typedef enum logic [1:0] {
        CFG_QUANTUM_L1 = 2'd0,
        CFG_QUANTUM_L2 = 2'd1,
        CFG_QUANTUM_L3 = 2'd2
    } t_cfg_index;

    // ready queue slot of a level 1..3
    function automatic logic [1:0] level_queue(input logic [LEVEL_BITS-1:0] level);
        return level - 2'd1;
    endfunction

endpackage

@@ hw/rtl/multilevel_feedback_queue_scheduler.sv @@
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// three-level feedback task scheduler with an i/o wait queue
// ----------------------------------------------------------------------------
// usage:
//   events enter on the in channel (i_in_valid / o_in_ready) as a mode, a task
//   id and an outcome; every event gives exactly one result on the out
//   channel (o_out_valid / i_out_ready): granted task, its level, its quantum
//   and a result code.
//   the user writes the quanta of the three levels through i_cfg_we,
//   i_cfg_index and i_cfg_data only while idle; the block does not enforce it.
// throughput:
//   an event waits in an input register until the output register is free;
//   its result is registered there. one event per cycle is sustained while
//   i_out_ready stays high; every event costs a single pass through the
//   queue head and tail logic; each queue ram is read ahead at its next head.
// reset:
//   synchronous, active low. all queues empty, no running task, quanta back
//   to 1, 2 and 4. no clearing pass: the block takes events right after reset.
// stalls:
//   while the receiver holds i_out_ready low the result stays in the output
//   register; one more event may wait in the input register, then
//   o_in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "multilevel_feedback_queue_scheduler_macros.svh"

module multilevel_feedback_queue_scheduler #(
    parameter int QUEUE_DEPTH  = mfq_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = mfq_pkg::TASK_ID_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // event channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_mode,
    input  logic [TASK_ID_BITS-1:0]         i_task_id,
    input  logic [1:0]                      i_outcome,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [TASK_ID_BITS-1:0]         o_granted_task,
    output logic [mfq_pkg::LEVEL_BITS-1:0]  o_task_level,
    output logic [mfq_pkg::QUANTUM_BITS-1:0] o_quantum,
    output logic [2:0]                      o_result_code,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [mfq_pkg::QUANTUM_BITS-1:0] i_cfg_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    // wait queue entry: {level, task}
    localparam int DW = TASK_ID_BITS + mfq_pkg::LEVEL_BITS;

    // input register
    logic                    r_in_valid;
    logic [1:0]              r_in_mode;
    logic [TASK_ID_BITS-1:0] r_in_task;
    logic [1:0]              r_in_outcome;

    // output register
    logic                               r_out_valid;
    logic [TASK_ID_BITS-1:0]            r_granted_task;
    logic [mfq_pkg::LEVEL_BITS-1:0]     r_task_level;
    logic [mfq_pkg::QUANTUM_BITS-1:0]   r_quantum_out;
    mfq_pkg::t_result                   r_result_code;

    // quanta per level
    logic [mfq_pkg::QUANTUM_BITS-1:0] r_quantum [mfq_pkg::NUM_LEVELS];

    // running task
    logic                           r_run_valid;
    logic [TASK_ID_BITS-1:0]        r_run_task;
    logic [mfq_pkg::LEVEL_BITS-1:0] r_run_level;
    logic                           n_run_valid;
    logic [TASK_ID_BITS-1:0]        n_run_task;
    logic [mfq_pkg::LEVEL_BITS-1:0] n_run_level;

    // queue bookkeeping, one slot per queue
    logic [AW-1:0] r_head  [mfq_pkg::NUM_QUEUES];
    logic [CW-1:0] r_count [mfq_pkg::NUM_QUEUES];
    logic [AW-1:0] n_head  [mfq_pkg::NUM_QUEUES];
    logic [CW-1:0] n_count [mfq_pkg::NUM_QUEUES];
    logic [AW-1:0] tail    [mfq_pkg::NUM_QUEUES];
    logic          r_fwd   [mfq_pkg::NUM_QUEUES];
    logic [DW-1:0] r_fwd_data [mfq_pkg::NUM_QUEUES];
    logic [DW-1:0] head_data  [mfq_pkg::NUM_QUEUES];
    logic [DW-1:0] push_data  [mfq_pkg::NUM_QUEUES];
    logic [mfq_pkg::NUM_QUEUES-1:0] push;
    logic [mfq_pkg::NUM_QUEUES-1:0] pop;
    logic [mfq_pkg::NUM_QUEUES-1:0] full;
    logic [mfq_pkg::NUM_QUEUES-1:0] empty;

    // event decode
    logic                               advance;
    logic [mfq_pkg::LEVEL_BITS-1:0]     disp_lvl;
    logic [1:0]                         disp_q;
    logic [mfq_pkg::LEVEL_BITS-1:0]     exp_lvl;
    logic [1:0]                         exp_q;
    logic [TASK_ID_BITS-1:0]            wait_task;
    logic [mfq_pkg::LEVEL_BITS-1:0]     wait_lvl;
    logic [mfq_pkg::LEVEL_BITS-1:0]     io_dest;
    logic [1:0]                         io_q;

    logic [TASK_ID_BITS-1:0]            res_task;
    logic [mfq_pkg::LEVEL_BITS-1:0]     res_level;
    logic [mfq_pkg::QUANTUM_BITS-1:0]   res_quantum;
    mfq_pkg::t_result                   res_code;

    // handshake: the event moves on whenever the output register is free
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_mode    <= i_mode;
            r_in_task    <= i_task_id;
            r_in_outcome <= i_outcome;
        end
    end

    // configuration registers, kept in ready queue slot order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum[mfq_pkg::Q_L1] <= mfq_pkg::QUANTUM_L1_RST;
            r_quantum[mfq_pkg::Q_L2] <= mfq_pkg::QUANTUM_L2_RST;
            r_quantum[mfq_pkg::Q_L3] <= mfq_pkg::QUANTUM_L3_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mfq_pkg::CFG_QUANTUM_L1: r_quantum[mfq_pkg::Q_L1] <= i_cfg_data;
                mfq_pkg::CFG_QUANTUM_L2: r_quantum[mfq_pkg::Q_L2] <= i_cfg_data;
                mfq_pkg::CFG_QUANTUM_L3: r_quantum[mfq_pkg::Q_L3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // level picks
    always_comb begin
        if (!empty[mfq_pkg::Q_L1]) begin
            disp_lvl = mfq_pkg::LVL_1;
        end else if (!empty[mfq_pkg::Q_L2]) begin
            disp_lvl = mfq_pkg::LVL_2;
        end else if (!empty[mfq_pkg::Q_L3]) begin
            disp_lvl = mfq_pkg::LVL_3;
        end else begin
            disp_lvl = mfq_pkg::LVL_NONE;
        end
        disp_q    = mfq_pkg::level_queue(disp_lvl);
        // demotion: 1 to 2, 2 and 3 to 3
        exp_lvl   = (r_run_level >= mfq_pkg::LVL_2) ? mfq_pkg::LVL_3 : mfq_pkg::LVL_2;
        exp_q     = mfq_pkg::level_queue(exp_lvl);
        wait_task = head_data[mfq_pkg::Q_IO][TASK_ID_BITS-1:0];
        wait_lvl  = head_data[mfq_pkg::Q_IO][DW-1:TASK_ID_BITS];
        // promotion: 3 to 2, others to 1
        io_dest   = (wait_lvl == mfq_pkg::LVL_3) ? mfq_pkg::LVL_2 : mfq_pkg::LVL_1;
        io_q      = mfq_pkg::level_queue(io_dest);
    end

    // event handling
    always_comb begin
        push        = '0;
        pop         = '0;
        for (int q = 0; q < mfq_pkg::NUM_QUEUES; q++) begin
            push_data[q] = '0;
        end
        n_run_valid = r_run_valid;
        n_run_task  = r_run_task;
        n_run_level = r_run_level;
        res_task    = '0;
        res_level   = mfq_pkg::LVL_NONE;
        res_quantum = '0;
        res_code    = mfq_pkg::RES_OK;
        if (advance) begin
            unique case (r_in_mode)
                mfq_pkg::MODE_ADMIT: begin
                    if (full[mfq_pkg::Q_L1]) begin
                        res_code = mfq_pkg::RES_FULL;
                    end else begin
                        push[mfq_pkg::Q_L1]      = 1'b1;
                        push_data[mfq_pkg::Q_L1] = DW'(r_in_task);
                    end
                end
                mfq_pkg::MODE_DISPATCH: begin
                    if (r_run_valid) begin
                        res_code = mfq_pkg::RES_BUSY;
                    end else if (disp_lvl == mfq_pkg::LVL_NONE) begin
                        res_code = mfq_pkg::RES_EMPTY;
                    end else begin
                        pop[disp_q] = 1'b1;
                        n_run_valid = 1'b1;
                        n_run_task  = head_data[disp_q][TASK_ID_BITS-1:0];
                        n_run_level = disp_lvl;
                        res_task    = head_data[disp_q][TASK_ID_BITS-1:0];
                        res_level   = disp_lvl;
                        res_quantum = r_quantum[disp_q];
                    end
                end
                mfq_pkg::MODE_REPORT: begin
                    if (!r_run_valid) begin
                        res_code = mfq_pkg::RES_NOT_RUNNING;
                    end else begin
                        case (r_in_outcome)
                            mfq_pkg::OUT_EXPIRED: begin
                                if (full[exp_q]) begin
                                    res_code = mfq_pkg::RES_FULL;
                                end else begin
                                    push[exp_q]      = 1'b1;
                                    push_data[exp_q] = DW'(r_run_task);
                                end
                            end
                            mfq_pkg::OUT_IO_REQUEST: begin
                                if (full[mfq_pkg::Q_IO]) begin
                                    res_code = mfq_pkg::RES_FULL;
                                end else begin
                                    push[mfq_pkg::Q_IO]      = 1'b1;
                                    push_data[mfq_pkg::Q_IO] = {r_run_level, r_run_task};
                                end
                            end
                            // terminated, and the unused outcome code
                            default: ;
                        endcase
                        n_run_valid = 1'b0;
                        n_run_task  = '0;
                        n_run_level = mfq_pkg::LVL_NONE;
                    end
                end
                mfq_pkg::MODE_IO_DONE: begin
                    if (empty[mfq_pkg::Q_IO]) begin
                        res_code = mfq_pkg::RES_EMPTY;
                    end else begin
                        pop[mfq_pkg::Q_IO] = 1'b1;
                        res_task           = wait_task;
                        res_level          = io_dest;
                        if (full[io_q]) begin
                            res_code = mfq_pkg::RES_FULL;
                        end else begin
                            push[io_q]      = 1'b1;
                            push_data[io_q] = DW'(wait_task);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_run_task  <= '0;
            r_run_level <= mfq_pkg::LVL_NONE;
        end else begin
            r_run_valid <= n_run_valid;
            r_run_task  <= n_run_task;
            r_run_level <= n_run_level;
        end
    end

    // output register, holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_granted_task <= res_task;
            r_task_level   <= res_level;
            r_quantum_out  <= res_quantum;
            r_result_code  <= res_code;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_granted_task = r_granted_task;
    assign o_task_level   = r_task_level;
    assign o_quantum      = r_quantum_out;
    assign o_result_code  = r_result_code;

    // queues: ram storage, head and count in flops, next head read ahead
    for (genvar q = 0; q < mfq_pkg::NUM_QUEUES; q++) begin : g_queue
        localparam int W = (q == mfq_pkg::Q_IO) ? DW : TASK_ID_BITS;

        logic [CW:0]   tail_sum;
        logic [W-1:0]  ram_rdata;

        assign full[q]  = (r_count[q] == CW'(QUEUE_DEPTH));
        assign empty[q] = (r_count[q] == '0);

        always_comb begin
            // head + count wraps at most once
            tail_sum = {1'b0, CW'(r_head[q])} + {1'b0, r_count[q]};
            if (tail_sum >= (CW + 1)'(QUEUE_DEPTH)) begin
                tail_sum = tail_sum - (CW + 1)'(QUEUE_DEPTH);
            end
            tail[q] = tail_sum[AW-1:0];
            if (pop[q]) begin
                n_head[q] = (r_head[q] == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head[q] + 1'b1;
            end else begin
                n_head[q] = r_head[q];
            end
            n_count[q] = r_count[q] + CW'(push[q]) - CW'(pop[q]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_head[q]  <= '0;
                r_count[q] <= '0;
                r_fwd[q]   <= 1'b0;
            end else begin
                r_head[q]  <= n_head[q];
                r_count[q] <= n_count[q];
                // a write into the slot being read ahead bypasses the ram
                r_fwd[q]   <= push[q] && (tail[q] == n_head[q]);
            end
        end

        always_ff @(posedge i_clk) begin
            r_fwd_data[q] <= push_data[q];
        end

        mfq_ram #(
            .WIDTH (W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (push[q]),
            .i_waddr (tail[q]),
            .i_wdata (push_data[q][W-1:0]),
            .i_raddr (n_head[q]),
            .o_rdata (ram_rdata)
        );

        assign head_data[q] = r_fwd[q] ? r_fwd_data[q] : DW'(ram_rdata);
    end

    // checks
    `MFQ_ASSERT_NEXT(a_dispatch_starts_task, i_clk, i_rst_n,
        advance && (r_in_mode == mfq_pkg::MODE_DISPATCH) && !r_run_valid
            && (disp_lvl != mfq_pkg::LVL_NONE),
        r_run_valid && r_out_valid, "dispatch with a ready task did not start it")
    `MFQ_ASSERT_IMPL(a_run_level_valid, i_clk, i_rst_n, r_run_valid,
        (r_run_level == mfq_pkg::LVL_1) || (r_run_level == mfq_pkg::LVL_2)
            || (r_run_level == mfq_pkg::LVL_3),
        "running task without a level")
    `MFQ_ASSERT_IMPL(a_fwd_nonempty, i_clk, i_rst_n, r_fwd[mfq_pkg::Q_IO],
        r_count[mfq_pkg::Q_IO] != '0, "head bypass set on an empty wait queue")
    `MFQ_ASSERT_IMPL(a_l1_count_bound, i_clk, i_rst_n, 1'b1,
        r_count[mfq_pkg::Q_L1] <= CW'(QUEUE_DEPTH), "level one count above depth")

endmodule

@@ hw/rtl/mfq_ram.sv @@
// ----------------------------------------------------------------------------
// mfq_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on an address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
